// ===== sv/capsule_sdf_line_pixel_blend_assert.svh =====
// assertion macros for the capsule line shader
`ifndef CAPSULE_SDF_LINE_PIXEL_BLEND_ASSERT_SVH
`define CAPSULE_SDF_LINE_PIXEL_BLEND_ASSERT_SVH
// implication checked on the same edge
`define CSLB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cslb assertion failed");
// implication checked on the next edge
`define CSLB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cslb assertion failed");
`endif

// ===== sv/cslb_pkg.sv =====
// ----------------------------------------------------------------------------
// cslb_pkg
// shared constants and types of the capsule line shader
// ----------------------------------------------------------------------------
`default_nettype none
package cslb_pkg;
  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int PROJ_BITS      = 16;
  localparam int COLOR_BITS     = 8;
  localparam int COV_BITS       = 9;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_START_X    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_Y    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_X      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_Y      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INK_RED    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_INK_GREEN  = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_INK_BLUE   = 3'd7;

  typedef enum logic [1:0] {PROJ_ZERO, PROJ_ONE, PROJ_DIV} proj_t;

  typedef struct packed {
    logic  vld;
    proj_t code;
  } ctl_t;
endpackage
`default_nettype wire

// ===== sv/cslb_front.sv =====
// ----------------------------------------------------------------------------
// cslb_front
// offsets from segment start, dot product, squared length, projection class
// ----------------------------------------------------------------------------
`default_nettype none
module cslb_front import cslb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int SIDE_W     = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            vld_i,
  input  wire logic [COORD_BITS-1:0]           px_i,
  input  wire logic [COORD_BITS-1:0]           py_i,
  input  wire logic [COORD_BITS+FRAC_BITS-1:0] sx_i,
  input  wire logic [COORD_BITS+FRAC_BITS-1:0] sy_i,
  input  wire logic [COORD_BITS+FRAC_BITS-1:0] ex_i,
  input  wire logic [COORD_BITS+FRAC_BITS-1:0] ey_i,
  input  wire logic [SIDE_W-1:0]               side_i,
  output ctl_t                                 ctl_o,
  output logic [2*(COORD_BITS+FRAC_BITS+1)-1:0] dot_o,
  output logic [2*(COORD_BITS+FRAC_BITS+1)-1:0] len2_o,
  output logic signed [COORD_BITS+FRAC_BITS:0] pax_o,
  output logic signed [COORD_BITS+FRAC_BITS:0] pay_o,
  output logic signed [COORD_BITS+FRAC_BITS:0] bax_o,
  output logic signed [COORD_BITS+FRAC_BITS:0] bay_o,
  output logic [SIDE_W-1:0]                    side_o
);
  localparam int D  = COORD_BITS + FRAC_BITS + 1;
  localparam int LW = 2 * D;
  localparam int DW = 2 * D + 1;

  logic [2:0] vld_r;
  logic signed [D-1:0] pax_a_r, pay_a_r, bax_a_r, bay_a_r;
  logic signed [D-1:0] pax_b_r, pay_b_r, bax_b_r, bay_b_r;
  logic signed [LW-1:0] p1_r, p2_r, q1_r, q2_r;
  logic [SIDE_W-1:0] side_a_r, side_b_r;
  logic signed [DW-1:0] dot_nxt;
  logic [LW-1:0] len2_nxt;
  proj_t code_nxt, code_r;

  always_comb begin
    dot_nxt  = DW'(p1_r) + DW'(p2_r);
    len2_nxt = LW'(q1_r) + LW'(q2_r);
    if (len2_nxt == '0 || dot_nxt[DW-1] || dot_nxt == '0) begin
      code_nxt = PROJ_ZERO;
    end else if (dot_nxt >= $signed({1'b0, len2_nxt})) begin
      code_nxt = PROJ_ONE;
    end else begin
      code_nxt = PROJ_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    pax_a_r  <= $signed({1'b0, px_i, {FRAC_BITS{1'b0}}}) - $signed({1'b0, sx_i});
    pay_a_r  <= $signed({1'b0, py_i, {FRAC_BITS{1'b0}}}) - $signed({1'b0, sy_i});
    bax_a_r  <= $signed({1'b0, ex_i}) - $signed({1'b0, sx_i});
    bay_a_r  <= $signed({1'b0, ey_i}) - $signed({1'b0, sy_i});
    side_a_r <= side_i;
    p1_r     <= pax_a_r * bax_a_r;
    p2_r     <= pay_a_r * bay_a_r;
    q1_r     <= bax_a_r * bax_a_r;
    q2_r     <= bay_a_r * bay_a_r;
    pax_b_r  <= pax_a_r;
    pay_b_r  <= pay_a_r;
    bax_b_r  <= bax_a_r;
    bay_b_r  <= bay_a_r;
    side_b_r <= side_a_r;
    dot_o    <= dot_nxt[LW-1:0];
    len2_o   <= len2_nxt;
    code_r   <= code_nxt;
    pax_o    <= pax_b_r;
    pay_o    <= pay_b_r;
    bax_o    <= bax_b_r;
    bay_o    <= bay_b_r;
    side_o   <= side_b_r;
  end

  assign ctl_o.vld  = vld_r[2];
  assign ctl_o.code = code_r;
endmodule
`default_nettype wire

// ===== sv/cslb_div.sv =====
// ----------------------------------------------------------------------------
// cslb_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module cslb_div import cslb_pkg::*; #(
  parameter int LW     = 38,
  parameter int SIDE_W = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  ctl_t                   ctl_i,
  input  wire logic [LW-1:0]     dot_i,
  input  wire logic [LW-1:0]     den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic [PROJ_BITS:0]     t_o,
  output logic [SIDE_W-1:0]      side_o
);
  localparam int N = PROJ_BITS;

  logic          vld_r  [N];
  proj_t         code_r [N];
  logic [LW-1:0] rem_r  [N];
  logic [LW-1:0] den_r  [N];
  logic [N-1:0]  q_r    [N];
  logic [SIDE_W-1:0] side_r [N];

  logic          vld_in  [N];
  proj_t         code_in [N];
  logic [LW-1:0] rem_in  [N];
  logic [LW-1:0] den_in  [N];
  logic [N-1:0]  q_in    [N];
  logic [SIDE_W-1:0] side_in [N];
  logic [LW:0]   r2      [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        vld_in[i]  = ctl_i.vld;
        code_in[i] = ctl_i.code;
        rem_in[i]  = dot_i;
        den_in[i]  = den_i;
        q_in[i]    = '0;
        side_in[i] = side_i;
      end else begin
        vld_in[i]  = vld_r[i-1];
        code_in[i] = code_r[i-1];
        rem_in[i]  = rem_r[i-1];
        den_in[i]  = den_r[i-1];
        q_in[i]    = q_r[i-1];
        side_in[i] = side_r[i-1];
      end
      r2[i] = {rem_in[i], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) vld_r[i] <= 1'b0;
    end else begin
      for (int i = 0; i < N; i++) vld_r[i] <= vld_in[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      code_r[i] <= code_in[i];
      den_r[i]  <= den_in[i];
      side_r[i] <= side_in[i];
      if (r2[i] >= {1'b0, den_in[i]}) begin
        rem_r[i] <= LW'(r2[i] - {1'b0, den_in[i]});
        q_r[i]   <= {q_in[i][N-2:0], 1'b1};
      end else begin
        rem_r[i] <= r2[i][LW-1:0];
        q_r[i]   <= {q_in[i][N-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    case (code_r[N-1])
      PROJ_ZERO: t_o = '0;
      PROJ_ONE:  t_o = {1'b1, {N{1'b0}}};
      PROJ_DIV:  t_o = {1'b0, q_r[N-1]};
      default:   t_o = '0;
    endcase
  end

  assign vld_o  = vld_r[N-1];
  assign side_o = side_r[N-1];
endmodule
`default_nettype wire

// ===== sv/cslb_dist.sv =====
// ----------------------------------------------------------------------------
// cslb_dist
// offset from the projected point and pipelined integer square root
// ----------------------------------------------------------------------------
`default_nettype none
module cslb_dist import cslb_pkg::*; #(
  parameter int D      = 19,
  parameter int SIDE_W = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                vld_i,
  input  wire logic [PROJ_BITS:0]  t_i,
  input  wire logic signed [D-1:0] pax_i,
  input  wire logic signed [D-1:0] pay_i,
  input  wire logic signed [D-1:0] bax_i,
  input  wire logic signed [D-1:0] bay_i,
  input  wire logic [SIDE_W-1:0]   side_i,
  output logic                     vld_o,
  output logic [D+2:0]             dist_o,
  output logic [SIDE_W-1:0]        side_o
);
  localparam int P  = PROJ_BITS;
  localparam int MW = D + P + 2;
  localparam int DX = D + 2;
  localparam int R  = DX + 1;
  localparam int SQ = 2 * R;

  logic [3:0] vld_r;
  logic signed [MW-1:0] mx_r, my_r;
  logic signed [D-1:0] pax_r, pay_r;
  logic [SIDE_W-1:0] side1_r, side2_r, side3_r, side4_r;
  logic signed [MW-1:0] fx, fy;
  logic [MW-1:0] magx, magy;
  logic [MW:0] rndx, rndy;
  logic [DX-1:0] dx_r, dy_r;
  logic [2*DX-1:0] sqx_r, sqy_r;
  logic [SQ-1:0] rad_r4;

  logic            svld_r  [R];
  logic [SQ-1:0]   rad_r   [R];
  logic [R+1:0]    rem_r   [R];
  logic [R-1:0]    root_r  [R];
  logic [SIDE_W-1:0] sside_r [R];
  logic            svld_in [R];
  logic [SQ-1:0]   rad_in  [R];
  logic [R+1:0]    rem_in  [R];
  logic [R-1:0]    root_in [R];
  logic [SIDE_W-1:0] sside_in [R];
  logic [R+3:0]    tv      [R];
  logic [R+3:0]    sub     [R];

  always_comb begin
    fx   = MW'($signed({pax_r, {P{1'b0}}})) - mx_r;
    fy   = MW'($signed({pay_r, {P{1'b0}}})) - my_r;
    magx = fx[MW-1] ? MW'(-fx) : MW'(fx);
    magy = fy[MW-1] ? MW'(-fy) : MW'(fy);
    rndx = {1'b0, magx} + (MW+1)'(1 << (P - 1));
    rndy = {1'b0, magy} + (MW+1)'(1 << (P - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    mx_r    <= bax_i * $signed({1'b0, t_i});
    my_r    <= bay_i * $signed({1'b0, t_i});
    pax_r   <= pax_i;
    pay_r   <= pay_i;
    side1_r <= side_i;
    dx_r    <= rndx[P+DX-1:P];
    dy_r    <= rndy[P+DX-1:P];
    side2_r <= side1_r;
    sqx_r   <= dx_r * dx_r;
    sqy_r   <= dy_r * dy_r;
    side3_r <= side2_r;
    rad_r4  <= SQ'(sqx_r) + SQ'(sqy_r);
    side4_r <= side3_r;
  end

  always_comb begin
    for (int k = 0; k < R; k++) begin
      if (k == 0) begin
        svld_in[k]  = vld_r[3];
        rad_in[k]   = rad_r4;
        rem_in[k]   = '0;
        root_in[k]  = '0;
        sside_in[k] = side4_r;
      end else begin
        svld_in[k]  = svld_r[k-1];
        rad_in[k]   = rad_r[k-1];
        rem_in[k]   = rem_r[k-1];
        root_in[k]  = root_r[k-1];
        sside_in[k] = sside_r[k-1];
      end
      tv[k]  = {rem_in[k], rad_in[k][SQ-1 -: 2]};
      sub[k] = {2'b00, root_in[k], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < R; k++) svld_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k < R; k++) svld_r[k] <= svld_in[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < R; k++) begin
      rad_r[k]   <= {rad_in[k][SQ-3:0], 2'b00};
      sside_r[k] <= sside_in[k];
      if (tv[k] >= sub[k]) begin
        rem_r[k]  <= (R+2)'(tv[k] - sub[k]);
        root_r[k] <= {root_in[k][R-2:0], 1'b1};
      end else begin
        rem_r[k]  <= tv[k][R+1:0];
        root_r[k] <= {root_in[k][R-2:0], 1'b0};
      end
    end
  end

  assign vld_o  = svld_r[R-1];
  assign dist_o = root_r[R-1];
  assign side_o = sside_r[R-1];
endmodule
`default_nettype wire

// ===== sv/cslb_blend.sv =====
// ----------------------------------------------------------------------------
// cslb_blend
// coverage from distance and radius, per-channel alpha blend
// ----------------------------------------------------------------------------
`default_nettype none
module cslb_blend import cslb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int R         = 22
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    vld_i,
  input  wire logic [R-1:0]            dist_i,
  input  wire logic [FRAC_BITS+4:0]    hw_i,
  input  wire logic [3*COLOR_BITS-1:0] old_i,
  input  wire logic [3*COLOR_BITS-1:0] ink_i,
  output logic                         vld_o,
  output logic [3*COLOR_BITS-1:0]      new_o,
  output logic [COV_BITS-1:0]          cov_o
);
  localparam int AW = R + 2;

  logic [2:0] vld_r;
  logic signed [AW-1:0] alpha;
  logic [FRAC_BITS:0] alpha_c;
  logic [FRAC_BITS+8:0] cov_w;
  logic [COV_BITS-1:0] cov1_r, cov2_r;
  logic [3*COLOR_BITS-1:0] old1_r;
  logic [2*COLOR_BITS:0] po_r [3];
  logic [2*COLOR_BITS:0] pi_r [3];
  logic [2*COLOR_BITS+1:0] sum [3];

  always_comb begin
    alpha = AW'(1 << (FRAC_BITS - 1)) + $signed(AW'(hw_i)) - $signed(AW'(dist_i));
    if (alpha[AW-1]) begin
      alpha_c = '0;
    end else if (alpha > $signed(AW'(1 << FRAC_BITS))) begin
      alpha_c = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      alpha_c = alpha[FRAC_BITS:0];
    end
    cov_w = {alpha_c, 8'd0} >> FRAC_BITS;
    for (int c = 0; c < 3; c++) sum[c] = {1'b0, po_r[c]} + {1'b0, pi_r[c]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    cov1_r <= cov_w[COV_BITS-1:0];
    old1_r <= old_i;
    cov2_r <= cov1_r;
    for (int c = 0; c < 3; c++) begin
      po_r[c] <= old1_r[c*COLOR_BITS +: COLOR_BITS] * (COV_BITS'(256) - cov1_r);
      pi_r[c] <= ink_i[c*COLOR_BITS +: COLOR_BITS] * cov1_r;
      new_o[c*COLOR_BITS +: COLOR_BITS] <= sum[c][2*COLOR_BITS-1:COLOR_BITS];
    end
    cov_o <= cov2_r;
  end

  assign vld_o = vld_r[2];
endmodule
`default_nettype wire

// ===== sv/capsule_sdf_line_pixel_blend.sv =====
// throughput: one pixel per cycle, busy is low whenever out of reset
// the depth is set by the one-bit-per-stage projection divider and square root
// reset: synchronous active low, clears the pipeline valid bits and loads register defaults
// the receiver cannot stall, so results leave on a one-cycle out_valid strobe
`default_nettype none
module capsule_sdf_line_pixel_blend import cslb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int CFG_W = (COORD_BITS + FRAC_BITS > FRAC_BITS + 5) ?
                         COORD_BITS + FRAC_BITS : FRAC_BITS + 5
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [COORD_BITS-1:0]   in_pixel_x,
  input  wire logic [COORD_BITS-1:0]   in_pixel_y,
  input  wire logic [COLOR_BITS-1:0]   in_old_red,
  input  wire logic [COLOR_BITS-1:0]   in_old_green,
  input  wire logic [COLOR_BITS-1:0]   in_old_blue,
  output logic                         out_valid,
  output logic [COLOR_BITS-1:0]        out_new_red,
  output logic [COLOR_BITS-1:0]        out_new_green,
  output logic [COLOR_BITS-1:0]        out_new_blue,
  output logic [COV_BITS-1:0]          out_coverage,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]        cfg_data
);
  localparam int POS     = COORD_BITS + FRAC_BITS;
  localparam int D       = POS + 1;
  localparam int LW      = 2 * D;
  localparam int R       = D + 3;
  localparam int CW3     = 3 * COLOR_BITS;
  localparam int SIDE_W  = 4 * D + CW3;
  localparam int LATENCY = 3 + PROJ_BITS + 4 + R + 3;

  logic [POS-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [FRAC_BITS+4:0] hw_r;
  logic [COLOR_BITS-1:0] ink_r_r, ink_g_r, ink_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r    <= '0;
      sy_r    <= '0;
      ex_r    <= '0;
      ey_r    <= '0;
      hw_r    <= (FRAC_BITS+5)'(128);
      ink_r_r <= COLOR_BITS'(255);
      ink_g_r <= '0;
      ink_b_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_START_X:    sx_r    <= cfg_data[POS-1:0];
        REG_START_Y:    sy_r    <= cfg_data[POS-1:0];
        REG_END_X:      ex_r    <= cfg_data[POS-1:0];
        REG_END_Y:      ey_r    <= cfg_data[POS-1:0];
        REG_HALF_WIDTH: hw_r    <= cfg_data[FRAC_BITS+4:0];
        REG_INK_RED:    ink_r_r <= cfg_data[COLOR_BITS-1:0];
        REG_INK_GREEN:  ink_g_r <= cfg_data[COLOR_BITS-1:0];
        REG_INK_BLUE:   ink_b_r <= cfg_data[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = !rst_n;

  ctl_t f_ctl;
  logic [LW-1:0] f_dot, f_len2;
  logic signed [D-1:0] f_pax, f_pay, f_bax, f_bay;
  logic [CW3-1:0] f_side;

  cslb_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .SIDE_W(CW3)) u_front (
    .clk, .rst_n,
    .vld_i(start && !busy), .px_i(in_pixel_x), .py_i(in_pixel_y),
    .sx_i(sx_r), .sy_i(sy_r), .ex_i(ex_r), .ey_i(ey_r),
    .side_i({in_old_blue, in_old_green, in_old_red}),
    .ctl_o(f_ctl), .dot_o(f_dot), .len2_o(f_len2),
    .pax_o(f_pax), .pay_o(f_pay), .bax_o(f_bax), .bay_o(f_bay), .side_o(f_side)
  );

  logic d_vld;
  logic [PROJ_BITS:0] d_t;
  logic [SIDE_W-1:0] d_side;

  cslb_div #(.LW(LW), .SIDE_W(SIDE_W)) u_div (
    .clk, .rst_n, .ctl_i(f_ctl), .dot_i(f_dot), .den_i(f_len2),
    .side_i({f_pax, f_pay, f_bax, f_bay, f_side}),
    .vld_o(d_vld), .t_o(d_t), .side_o(d_side)
  );

  logic s_vld;
  logic [R-1:0] s_dist;
  logic [CW3-1:0] s_side;

  cslb_dist #(.D(D), .SIDE_W(CW3)) u_dist (
    .clk, .rst_n, .vld_i(d_vld), .t_i(d_t),
    .pax_i(d_side[CW3+3*D +: D]), .pay_i(d_side[CW3+2*D +: D]),
    .bax_i(d_side[CW3+D +: D]), .bay_i(d_side[CW3 +: D]),
    .side_i(d_side[CW3-1:0]),
    .vld_o(s_vld), .dist_o(s_dist), .side_o(s_side)
  );

  logic [CW3-1:0] b_new;

  cslb_blend #(.FRAC_BITS(FRAC_BITS), .R(R)) u_blend (
    .clk, .rst_n, .vld_i(s_vld), .dist_i(s_dist), .hw_i(hw_r),
    .old_i(s_side), .ink_i({ink_b_r, ink_g_r, ink_r_r}),
    .vld_o(out_valid), .new_o(b_new), .cov_o(out_coverage)
  );

  assign out_new_red   = b_new[0 +: COLOR_BITS];
  assign out_new_green = b_new[COLOR_BITS +: COLOR_BITS];
  assign out_new_blue  = b_new[2*COLOR_BITS +: COLOR_BITS];
endmodule
`default_nettype wire

// ===== sv/cslb_checker.sv =====
// ----------------------------------------------------------------------------
// cslb_checker
// port-level checks of the capsule line shader, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "capsule_sdf_line_pixel_blend_assert.svh"
module cslb_checker import cslb_pkg::*; #(
  parameter int LAT = 48
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic [COLOR_BITS-1:0] in_old_red,
  input wire logic                  out_valid,
  input wire logic [COLOR_BITS-1:0] out_new_red,
  input wire logic [COV_BITS-1:0]   out_coverage
);
  `CSLB_ASSERT_IMP(a_busy_low, 1'b1, !busy)
  `CSLB_ASSERT_IMP(a_no_phantom, out_valid, $past(start && !busy, LAT))
  `CSLB_ASSERT_IMP(a_cov_range, out_valid, out_coverage <= COV_BITS'(256))
  `CSLB_ASSERT_IMP(a_zero_cov_keeps, out_valid && out_coverage == '0, out_new_red == $past(in_old_red, LAT))
endmodule

bind capsule_sdf_line_pixel_blend cslb_checker #(.LAT(LATENCY)) u_cslb_checker (
  .clk, .rst_n, .start, .busy, .in_old_red, .out_valid, .out_new_red, .out_coverage
);
`default_nettype wire
